// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, held off while reset is active
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check, also active during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== rtl/mnpt_pkg.sv =====
package mnpt_pkg;

    // event kinds
    localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
    localparam logic [1:0] MODE_OTHER    = 2'd2;
    localparam logic [1:0] MODE_END      = 2'd3;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_COMPLETED = 3'd1;
    localparam logic [2:0] ST_UNMATCHED = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    localparam logic [31:0] DUR_MAX = 32'hFFFF_FFFF;

    // one input event
    typedef struct packed {
        logic [1:0]  mode;
        logic [27:0] delta_time;
        logic [3:0]  channel;
        logic [6:0]  key;
        logic [6:0]  velocity;
    } t_in;

    // one result
    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  note_channel;
        logic [6:0]  note_key;
        logic [6:0]  note_velocity;
        logic [31:0] note_duration;
        logic [23:0] note_start_index;
        logic [4:0]  open_count;
    } t_out;

    // note identity held in a table cell
    typedef struct packed {
        logic [3:0] channel;
        logic [6:0] key;
        logic [6:0] velocity;
    } t_note;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_SELECT,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic update;
        logic select;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_note_off;
    } t_stat;

endpackage

// ===== rtl/midi_note_pair_tracker.sv =====
// MIDI note pair tracker. Events go in through start/busy: an event transfers
// at a rising edge with start high and busy low. Each event yields exactly one
// result, shown on o_result for a single cycle with o_valid high; there is no
// way to hold a result off, so the receiver must take it in that cycle. An
// event passes through the sequencer steps in order: update of all open notes,
// one extra step to pick and remove the oldest matching note for a note-off,
// then the result cycle; no new event is taken until these are done. The
// result cycle is the last busy cycle. Open notes are held in MAX_OPEN_NOTES
// cells in age order; all cells age in parallel. Notes still open at end of
// track are dropped without a result.
module midi_note_pair_tracker
    import mnpt_pkg::*;
#(
    parameter int MAX_OPEN_NOTES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    mnpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // note table and result register
    mnpt_datapath #(
        .MAX_OPEN_NOTES (MAX_OPEN_NOTES)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

// ===== rtl/mnpt_ctrl.sv =====
`include "assert_macros.svh"

module mnpt_ctrl
    import mnpt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output logic  busy,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = i_stat.is_note_off ? S_SELECT : S_DONE;
            end
            S_SELECT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        busy         = 1'b1;
        o_valid      = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_SELECT: begin
                o_cmd.select = 1'b1;
            end
            S_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

    // a result strobe lasts a single cycle
    `ASSERT_CLK(a_strobe_single, i_clk, i_rst_n, o_valid |=> !o_valid)
    // a transfer in always leads to the update step
    `ASSERT_CLK(a_load_update, i_clk, i_rst_n, o_cmd.load |=> o_cmd.update)
    // the strobe only follows an update or select step
    `ASSERT_CLK(a_strobe_src, i_clk, i_rst_n,
                o_valid |-> ($past(o_cmd.update) || $past(o_cmd.select)))

endmodule

// ===== rtl/mnpt_datapath.sv =====
`include "assert_macros.svh"

module mnpt_datapath
    import mnpt_pkg::*;
#(
    parameter int MAX_OPEN_NOTES = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_in   i_item,
    output t_stat o_stat,
    output t_out  o_result
);

    localparam int N  = MAX_OPEN_NOTES;
    localparam int CW = $clog2(N + 1);

    // latched event
    t_in r_in;

    // table cells, kept in age order: cell 0 holds the oldest open note
    logic [N-1:0]  r_valid, n_valid;
    t_note         r_note  [N];
    t_note         n_note  [N];
    logic [31:0]   r_dur   [N];
    logic [31:0]   n_dur   [N];
    logic [23:0]   r_start [N];
    logic [23:0]   n_start [N];
    logic [N-1:0]  r_match, n_match;
    logic [CW-1:0] r_count, n_count;
    logic [23:0]   r_pos, n_pos;
    t_out          r_res, n_res;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_item;
        r_note  <= n_note;
        r_dur   <= n_dur;
        r_start <= n_start;
        r_match <= n_match;
        r_res   <= n_res;
    end

    // table update and note selection
    always_comb begin
        logic [32:0]   sum;
        logic [N-1:0]  pre;
        logic [N-1:0]  first;
        t_note         sel_note;
        logic [31:0]   sel_dur;
        logic [23:0]   sel_start;
        logic [CW+4:0] oc_wide;

        sum     = '0;
        n_valid = r_valid;
        n_note  = r_note;
        n_dur   = r_dur;
        n_start = r_start;
        n_match = r_match;
        n_count = r_count;
        n_pos   = r_pos;
        n_res   = r_res;

        // prefix or of the match vector: cells at or above the oldest hit
        pre = r_match;
        for (int s = 1; s < N; s = s * 2) begin
            pre = pre | (pre << s);
        end
        first = pre & ~(pre << 1);

        // and-or pick of the oldest matching cell
        sel_note  = '0;
        sel_dur   = '0;
        sel_start = '0;
        for (int i = 0; i < N; i++) begin
            if (first[i]) begin
                sel_note  = sel_note | r_note[i];
                sel_dur   = sel_dur | r_dur[i];
                sel_start = sel_start | r_start[i];
            end
        end

        if (i_cmd.update) begin
            // age every open note and look up the key
            for (int i = 0; i < N; i++) begin
                sum = {1'b0, r_dur[i]} + {5'b0, r_in.delta_time};
                if (r_valid[i]) n_dur[i] = sum[32] ? DUR_MAX : sum[31:0];
                n_match[i] = r_valid[i] && (r_note[i].channel == r_in.channel)
                             && (r_note[i].key == r_in.key);
            end
            n_res = '0;
            n_pos = r_pos + 24'd1;
            case (r_in.mode)
                MODE_END: begin
                    n_valid      = '0;
                    n_count      = '0;
                    n_pos        = '0;
                    n_res.status = ST_CLEARED;
                end
                MODE_NOTE_ON: begin
                    if (r_count == CW'(N)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        // append behind the youngest open note
                        for (int i = 0; i < N; i++) begin
                            if (CW'(i) == r_count) begin
                                n_valid[i] = 1'b1;
                                n_note[i]  = '{channel: r_in.channel, key: r_in.key,
                                               velocity: r_in.velocity};
                                n_dur[i]   = '0;
                                n_start[i] = r_pos;
                            end
                        end
                        n_count      = r_count + CW'(1);
                        n_res.status = ST_ACCEPTED;
                    end
                end
                MODE_NOTE_OFF: begin
                    n_res.status = ST_UNMATCHED;
                end
                MODE_OTHER: begin
                    n_res.status = ST_ACCEPTED;
                end
                default: begin
                    n_res.status = ST_ACCEPTED;
                end
            endcase
        end

        if (i_cmd.select) begin
            if (|r_match) begin
                // report the note and close the gap it leaves
                n_res.status           = ST_COMPLETED;
                n_res.note_channel     = sel_note.channel;
                n_res.note_key         = sel_note.key;
                n_res.note_velocity    = sel_note.velocity;
                n_res.note_duration    = sel_dur;
                n_res.note_start_index = sel_start;
                for (int i = 0; i < N - 1; i++) begin
                    if (pre[i]) begin
                        n_valid[i] = r_valid[i+1];
                        n_note[i]  = r_note[i+1];
                        n_dur[i]   = r_dur[i+1];
                        n_start[i] = r_start[i+1];
                    end
                end
                if (pre[N-1]) n_valid[N-1] = 1'b0;
                n_count = r_count - CW'(1);
            end else begin
                n_res.status = ST_UNMATCHED;
            end
        end

        // open count after the event, low five bits
        oc_wide = {5'b0, n_count};
        if (i_cmd.update || i_cmd.select) n_res.open_count = oc_wide[4:0];
    end

    assign o_stat.is_note_off = (r_in.mode == MODE_NOTE_OFF);
    assign o_result           = r_res;

    // open cells always form a prefix whose length is the count
    `ASSERT_CLK(a_count_valid, i_clk, i_rst_n, $countones(r_valid) == int'(r_count))
    `ASSERT_CLK(a_valid_prefix, i_clk, i_rst_n, ((r_valid + 1'b1) & r_valid) == '0)
    // a completed note always leaves one cell fewer
    `ASSERT_CLK(a_remove_count, i_clk, i_rst_n,
                (i_cmd.select && (|r_match)) |=> (r_count == $past(r_count) - CW'(1)))

endmodule
